// ===== rtl/sme_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sparse matrix element store.
// No dependencies.
package sme_pkg;

  localparam int RowFieldW = 6;
  localparam int ColFieldW = 6;
  localparam int ValW      = 64;
  localparam int StatW     = 3;
  localparam int TotalW    = 13;
  localparam logic [62:0] ThreshReset = 63'h3CB0_0000_0000_0000;

  localparam logic [StatW-1:0] ST_READ_HIT  = 3'd0;
  localparam logic [StatW-1:0] ST_READ_MISS = 3'd1;
  localparam logic [StatW-1:0] ST_UPDATED   = 3'd2;
  localparam logic [StatW-1:0] ST_INSERTED  = 3'd3;
  localparam logic [StatW-1:0] ST_REMOVED   = 3'd4;
  localparam logic [StatW-1:0] ST_IGNORED   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_CNT, S_INIT, S_SRCH, S_SCMP, S_HCMP, S_DECIDE,
    S_DNRD, S_DNWR, S_UPRD, S_UPWR, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cnt_rd;
    logic srch_init;
    logic mid_rd;
    logic mid_cmp;
    logic pos_rd;
    logic hit_cmp;
    logic hit_clr;
    logic dn_init;
    logic up_init;
    logic shf_rd_dn;
    logic shf_rd_up;
    logic shf_wr;
    logic upd_wr;
    logic ins_wr;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic act;
    logic below_thr;
    logic hit;
    logic lo_lt_hi;
    logic pos_lt_cnt;
    logic dn_more;
    logic up_more;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/sme_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: search, shift and result sequencing.
// Depends on sme_pkg.
module sme_ctrl
  import sme_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  stat_t  st,
  output logic   idle,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_CNT;
      S_CNT:    state_nxt = st.oor ? S_OUT : S_INIT;
      S_INIT:   state_nxt = S_SRCH;
      S_SRCH: begin
        if (st.lo_lt_hi) state_nxt = S_SCMP;
        else if (st.pos_lt_cnt) state_nxt = S_HCMP;
        else state_nxt = S_DECIDE;
      end
      S_SCMP:   state_nxt = S_SRCH;
      S_HCMP:   state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!st.act) state_nxt = S_OUT;
        else if (st.below_thr) state_nxt = st.hit ? S_DNRD : S_OUT;
        else state_nxt = st.hit ? S_FIN : S_UPRD;
      end
      S_DNRD:   state_nxt = st.dn_more ? S_DNWR : S_FIN;
      S_DNWR:   state_nxt = S_DNRD;
      S_UPRD:   state_nxt = st.up_more ? S_UPWR : S_FIN;
      S_UPWR:   state_nxt = S_UPRD;
      S_FIN:    state_nxt = S_OUT;
      S_OUT:    if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle       = 1'b1;
        cmd.accept = in_fire;
      end
      S_CNT:    cmd.cnt_rd = 1'b1;
      S_INIT:   cmd.srch_init = 1'b1;
      S_SRCH: begin
        cmd.mid_rd  = st.lo_lt_hi;
        cmd.pos_rd  = !st.lo_lt_hi && st.pos_lt_cnt;
        cmd.hit_clr = !st.lo_lt_hi && !st.pos_lt_cnt;
      end
      S_SCMP:   cmd.mid_cmp = 1'b1;
      S_HCMP:   cmd.hit_cmp = 1'b1;
      S_DECIDE: begin
        cmd.dn_init = st.act && st.below_thr && st.hit;
        cmd.upd_wr  = st.act && !st.below_thr && st.hit;
        cmd.up_init = st.act && !st.below_thr && !st.hit;
      end
      S_DNRD:   cmd.shf_rd_dn = st.dn_more;
      S_DNWR:   cmd.shf_wr = 1'b1;
      S_UPRD: begin
        cmd.shf_rd_up = st.up_more;
        cmd.ins_wr    = !st.up_more;
      end
      S_UPWR:   cmd.shf_wr = 1'b1;
      S_FIN:    cmd.fin = 1'b1;
      S_OUT:    cmd.load_out = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/sme_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: entry and count memories, search bounds, shift index, result register.
// Depends on sme_pkg.
module sme_dpath
  import sme_pkg::*;
#(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  logic                 in_action,
  input  logic [RowFieldW-1:0] in_row,
  input  logic [ColFieldW-1:0] in_col,
  input  logic [ValW-1:0]      in_value,
  input  logic                 cfg_we,
  input  logic [62:0]          cfg_thr,
  input  logic                 out_tready,
  output logic                 out_valid,
  output logic [ValW-1:0]      out_value,
  output logic                 out_present,
  output logic [StatW-1:0]     out_status,
  output logic [TotalW-1:0]    out_total
);

  localparam int PW     = $clog2(ROWS + 1);
  localparam int CW     = $clog2(COLS);
  localparam int ADDR_W = $clog2(ROWS * COLS);
  localparam int TW     = $clog2(ROWS * COLS + 1);

  logic [RowFieldW-1:0] rows_mem [ROWS*COLS];
  logic [ValW-1:0]      vals_mem [ROWS*COLS];
  logic [PW-1:0]        cnt_mem  [COLS];
  logic [COLS-1:0]      col_v_r;

  logic                 act_r, oor_r, hit_r, dir_r;
  logic [RowFieldW-1:0] row_r;
  logic [CW-1:0]        col_r;
  logic [ValW-1:0]      val_r;
  logic [62:0]          thr_r;
  logic [PW-1:0]        lo_r, hi_r, mid_r, cnt_r, idx_r, cnt_d_r;
  logic                 cnt_v_r;
  logic [TW-1:0]        total_r;
  logic [RowFieldW-1:0] rrow_r;
  logic [ValW-1:0]      rval_r;

  logic                 out_valid_r;
  logic [ValW-1:0]      out_value_r;
  logic                 out_present_r;
  logic [StatW-1:0]     out_status_r;
  logic [TotalW-1:0]    out_total_r;

  logic [ADDR_W-1:0]    base, raddr, waddr;
  logic [PW-1:0]        mid;
  logic                 re, we;
  logic [RowFieldW-1:0] wrow;
  logic [ValW-1:0]      wval;
  logic                 below_thr;

  assign base      = ADDR_W'(32'(col_r) * ROWS);
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign below_thr = val_r[62:0] < thr_r;

  always_comb begin
    re    = 1'b1;
    raddr = base + ADDR_W'(lo_r);
    priority if (cmd.mid_rd) begin
      raddr = base + ADDR_W'(mid);
    end else if (cmd.shf_rd_dn) begin
      raddr = base + ADDR_W'(idx_r) + ADDR_W'(1);
    end else if (cmd.shf_rd_up) begin
      raddr = base + ADDR_W'(idx_r) - ADDR_W'(1);
    end else begin
      re = cmd.pos_rd;
    end
  end

  always_comb begin
    we    = cmd.shf_wr || cmd.upd_wr || cmd.ins_wr;
    waddr = cmd.shf_wr ? base + ADDR_W'(idx_r) : base + ADDR_W'(lo_r);
    wrow  = cmd.shf_wr ? rrow_r : row_r;
    wval  = cmd.shf_wr ? rval_r : val_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vals_mem[waddr] <= wval;
      if (!cmd.upd_wr) rows_mem[waddr] <= wrow;
    end
    if (re) begin
      rrow_r <= rows_mem[raddr];
      rval_r <= vals_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      cnt_d_r <= cnt_mem[col_r];
      cnt_v_r <= col_v_r[col_r];
    end
    if (cmd.fin && act_r && (below_thr == hit_r)) begin
      cnt_mem[col_r] <= hit_r ? cnt_r - PW'(1) : cnt_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_v_r     <= '0;
      total_r     <= '0;
      thr_r       <= ThreshReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_thr;
      if (cmd.fin && act_r && (below_thr == hit_r)) begin
        col_v_r[col_r] <= 1'b1;
        total_r <= hit_r ? total_r - TW'(1) : total_r + TW'(1);
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_action;
      row_r <= in_row;
      col_r <= CW'(in_col);
      val_r <= in_value;
      oor_r <= (32'(in_row) >= ROWS) || (32'(in_col) >= COLS);
    end
    if (cmd.srch_init) begin
      lo_r  <= '0;
      hi_r  <= cnt_v_r ? cnt_d_r : '0;
      cnt_r <= cnt_v_r ? cnt_d_r : '0;
    end
    if (cmd.mid_rd) mid_r <= mid;
    if (cmd.mid_cmp) begin
      if (rrow_r < row_r) lo_r <= mid_r + PW'(1);
      else hi_r <= mid_r;
    end
    if (cmd.hit_clr) hit_r <= 1'b0;
    if (cmd.hit_cmp) hit_r <= (rrow_r == row_r);
    if (cmd.dn_init) begin
      idx_r <= lo_r;
      dir_r <= 1'b0;
    end
    if (cmd.up_init) begin
      idx_r <= cnt_r;
      dir_r <= 1'b1;
    end
    if (cmd.shf_wr) idx_r <= dir_r ? idx_r - PW'(1) : idx_r + PW'(1);
    if (cmd.load_out) begin
      out_total_r <= TotalW'(total_r);
      priority if (oor_r) begin
        out_value_r   <= '0;
        out_present_r <= 1'b0;
        out_status_r  <= act_r ? ST_IGNORED : ST_READ_MISS;
      end else if (!act_r) begin
        out_value_r   <= hit_r ? rval_r : '0;
        out_present_r <= hit_r;
        out_status_r  <= hit_r ? ST_READ_HIT : ST_READ_MISS;
      end else if (below_thr) begin
        out_value_r   <= '0;
        out_present_r <= 1'b0;
        out_status_r  <= hit_r ? ST_REMOVED : ST_IGNORED;
      end else begin
        out_value_r   <= val_r;
        out_present_r <= 1'b1;
        out_status_r  <= hit_r ? ST_UPDATED : ST_INSERTED;
      end
    end
  end

  always_comb begin
    st.oor        = oor_r;
    st.act        = act_r;
    st.below_thr  = below_thr;
    st.hit        = hit_r;
    st.lo_lt_hi   = lo_r < hi_r;
    st.pos_lt_cnt = lo_r < cnt_r;
    st.dn_more    = ({1'b0, idx_r} + (PW+1)'(1)) < {1'b0, cnt_r};
    st.up_more    = idx_r > lo_r;
    st.out_free   = !out_valid_r || out_tready;
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_present = out_present_r;
  assign out_status  = out_status_r;
  assign out_total   = out_total_r;

endmodule

// ===== rtl/sparse_matrix_element_store.sv =====
`timescale 1ns / 1ps
// Sparse matrix element store: one word in, one word out, one at a time.
// The search takes s bisection steps (s <= ceil(log2(n+1)), n entries in the column),
// plus a hit compare when it lands on an entry; an update writes the entry in place, and an
// insert or removal shifts m entries (m < ROWS) with alternating reads and writes.
// Next word accepted in the cycle after the result registers, later while out_tready holds it.
// Reset clears column valid flags, total and out_tvalid and reloads the threshold; memories are not cleared.
module sparse_matrix_element_store
  import sme_pkg::*;
#(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // row_index[5:0], col_index[11:6], write_value[75:12]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // read_value[63:0], present[64], nonzero_total[77:65]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data    // zero_threshold[62:0]
);

  cmd_t  cmd;
  stat_t st;
  logic  idle;
  logic  in_fire;
  logic  [ValW-1:0]   rd_value;
  logic               rd_present;
  logic [TotalW-1:0]  rd_total;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;
  assign cfg_ready = 1'b1;

  sme_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .st      (st),
    .idle    (idle),
    .cmd     (cmd)
  );

  sme_dpath #(.ROWS(ROWS), .COLS(COLS)) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_action   (in_tuser[0]),
    .in_row      (in_tdata[5:0]),
    .in_col      (in_tdata[11:6]),
    .in_value    (in_tdata[75:12]),
    .cfg_we      (cfg_valid),
    .cfg_thr     (cfg_data[62:0]),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_value   (rd_value),
    .out_present (rd_present),
    .out_status  (out_tuser),
    .out_total   (rd_total)
  );

  assign out_tdata = {2'b00, rd_total, rd_present, rd_value};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("accepted a word while busy");

  a_present_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rd_present == ((out_tuser == ST_READ_HIT) ||
                   (out_tuser == ST_UPDATED) || (out_tuser == ST_INSERTED))))
    else $error("present flag disagrees with status");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !rd_present) |-> (rd_value == '0))
    else $error("absent element returned nonzero value");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(rd_total) <= ROWS * COLS))
    else $error("entry total exceeds capacity");

endmodule

// ===== tb/sv/sparse_matrix_element_store_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sparse_matrix_element_store: a column-list store model
// predicts each result word; bursty input, stalling output, threshold changes while idle.
// Depends on sme_pkg and the sparse_matrix_element_store RTL.
module sparse_matrix_element_store_tb;
  import sme_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        present;
    logic [2:0]  status;
    logic [12:0] total;
  } elem_result_t;

  class elem_scoreboard;
    logic [5:0]  rows[64][$];
    logic [63:0] vals[64][$];
    logic [62:0] threshold;
    int unsigned total;
    elem_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen[8];

    function void clear();
      foreach (rows[c]) begin
        rows[c].delete();
        vals[c].delete();
      end
      threshold = ThreshReset;
      total = 0;
    endfunction

    function void note_input(logic act, logic [5:0] row, logic [5:0] col,
                             logic [63:0] wv);
      elem_result_t r;
      int pos;
      bit hit;
      pos = 0;
      while (pos < rows[col].size() && rows[col][pos] < row) pos++;
      hit = pos < rows[col].size() && rows[col][pos] == row;
      r.value = '0;
      r.present = 1'b0;
      if (!act) begin
        if (hit) begin
          r.value = vals[col][pos];
          r.present = 1'b1;
          r.status = ST_READ_HIT;
        end else begin
          r.status = ST_READ_MISS;
        end
      end else if (wv[62:0] < threshold) begin
        if (hit) begin
          rows[col].delete(pos);
          vals[col].delete(pos);
          total--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_IGNORED;
        end
      end else if (hit) begin
        vals[col][pos] = wv;
        r.value = wv;
        r.present = 1'b1;
        r.status = ST_UPDATED;
      end else begin
        rows[col].insert(pos, row);
        vals[col].insert(pos, wv);
        total++;
        r.value = wv;
        r.present = 1'b1;
        r.status = ST_INSERTED;
      end
      r.total = total[12:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [79:0] data, logic [2:0] user);
      elem_result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      status_seen[e.status]++;
      if (data[63:0] !== e.value) begin
        $error("read_value exp %h got %h", e.value, data[63:0]);
        errors++;
      end
      if (data[64] !== e.present) begin
        $error("present exp %b got %b", e.present, data[64]);
        errors++;
      end
      if (data[77:65] !== e.total) begin
        $error("nonzero_total exp %0d got %0d", e.total, data[77:65]);
        errors++;
      end
      if (user !== e.status) begin
        $error("status exp %0d got %0d", e.status, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  elem_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned sent;
  int unsigned burst_left;
  bit          stall_mode = 1'b0;
  localparam int unsigned CycleLimit = 4000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sparse_matrix_element_store #(.ROWS(64), .COLS(64)) i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sparse_matrix_element_store: FAILED **");
      $finish;
    end
  end

  // receiver: alternate between free-running and random stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // valid stays up inside a burst; it drops only for a gap or an idle phase
  task automatic send_elem(logic act, logic [5:0] row, logic [5:0] col, logic [63:0] wv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0, wv, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, row, col, wv);
    sent++;
    burst_left--;
  endtask

  task automatic write_threshold(logic [63:0] th);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= th;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.threshold = th[62:0];
  endtask

  function automatic logic [63:0] rand_value(logic [62:0] th);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[62:0] = th;
      1: v[62:0] = th - 1;
      2: v[62:52] = 11'h7FF;
      3: v[62:0] = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_phase(int n, int span);
    logic [5:0] r, c;
    for (int k = 0; k < n; k++) begin
      r = 6'($urandom_range(0, span));
      c = 6'($urandom_range(0, span));
      send_elem($urandom_range(0, 2) != 0, r, c, rand_value(sb.threshold));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every status, boundary magnitudes
    send_elem(1'b0, 6'd0, 6'd0, '0);
    send_elem(1'b1, 6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    send_elem(1'b0, 6'd63, 6'd63, '0);
    send_elem(1'b1, 6'd0, 6'd63, 64'h3CB0_0000_0000_0000);
    send_elem(1'b1, 6'd31, 6'd63, 64'hBFF0_0000_0000_0000);
    send_elem(1'b1, 6'd31, 6'd63, 64'h7FF0_0000_0000_0000);
    send_elem(1'b0, 6'd31, 6'd63, '0);
    send_elem(1'b1, 6'd0, 6'd63, 64'h8000_0000_0000_0000);
    send_elem(1'b1, 6'd0, 6'd63, 64'h3CAF_FFFF_FFFF_FFFF);
    send_elem(1'b1, 6'd63, 6'd63, 64'h1);
    send_elem(1'b1, 6'd63, 6'd0, 64'hFFF8_0000_0000_0001);
    send_elem(1'b0, 6'd63, 6'd0, '0);
    send_elem(1'b0, 6'd62, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int r = 63; r >= 0; r -= 9)
      send_elem(1'b1, r[5:0], 6'd5, {$urandom, $urandom} | 64'h4000_0000_0000_0000);

    write_threshold(64'h0);
    send_elem(1'b1, 6'd1, 6'd1, 64'h0);
    write_threshold(64'hFFFF_FFFF_FFFF_FFFF);
    send_elem(1'b1, 6'd1, 6'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_elem(1'b1, 6'd63, 6'd5, 64'hFFEF_FFFF_FFFF_FFFF);
    write_threshold(64'h7FF0_0000_0000_0000);
    send_elem(1'b1, 6'd1, 6'd1, 64'hFFF0_0000_0000_0000);

    // random: dense small corner to fill columns, then full range, a 16x16 corner, full range again
    write_threshold(64'h3FF0_0000_0000_0000);
    random_phase(600, 7);
    write_threshold({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF);
    random_phase(500, 63);
    write_threshold(ThreshReset);
    random_phase(500, 15);
    write_threshold(64'h0);
    random_phase(400, 63);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d words sent, %0d results checked; hits %0d miss %0d upd %0d",
             sent, sb.checked, sb.status_seen[ST_READ_HIT], sb.status_seen[ST_READ_MISS],
             sb.status_seen[ST_UPDATED]);
    $display("ins %0d rem %0d ignored %0d, final entry count %0d",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_REMOVED],
             sb.status_seen[ST_IGNORED], sb.total);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** sparse_matrix_element_store: PASSED **");
    end else begin
      $display("** sparse_matrix_element_store: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sme_pkg.sv
rtl/sme_ctrl.sv
rtl/sme_dpath.sv
rtl/sparse_matrix_element_store.sv
tb/sv/sparse_matrix_element_store_tb.sv
